// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define B64E_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ===== hdl/b64e_pkg.sv =====
// Types, constants and the symbol table of the base64 stream encoder.
package b64e_pkg;

    localparam int B64E_QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;

    // Position of the next byte within its three-byte group.
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } b64e_phase_t;

    // One classified byte: up to four characters for the back end.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      cnt_m1;
        logic            last;
    } b64e_entry_t;

    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = CHAR_UPPER_A + {2'b00, v};
        else if (v < 6'd52)
            c = CHAR_LOWER_A + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            c = CHAR_DIGIT_0 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            c = CHAR_PLUS;
        else
            c = CHAR_SLASH;
        return c;
    endfunction

endpackage

// ===== hdl/b64e_in_if.sv =====
// Byte channel into the encoder.
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       msg_last;

    modport source (output valid, output data_byte, output msg_last, input ready);
    modport sink   (input valid, input data_byte, input msg_last, output ready);
endinterface

// ===== hdl/b64e_out_if.sv =====
// Character channel out of the encoder.
interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;

    modport source (output valid, output out_char, output out_last, input ready);
    modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

// ===== hdl/base64_stream_encoder_core.sv =====
// Top level of the base64 stream encoder.
// A byte's entry is queued; its characters then pass the output register that drives enc.
// It sends one character per cycle unless enc stalls or no entry waits; a byte gives one to
// four characters (one or two mid-message, two to four if last), 4/3 per byte over a group.
// Bytes are taken while earlier characters drain, as long as the entry queue has room.
// Reset: rst_n clears phase, carry, queue pointers and the output valid at once.
module base64_stream_encoder_core
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = B64E_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    b64e_in_if.sink     msg,
    b64e_out_if.source  enc
);

    b64e_entry_t push_data;
    b64e_entry_t head;
    logic        push;
    logic        full;
    logic        pop;
    logic        head_valid;

    b64e_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .q_full (full),
        .push   (push),
        .entry  (push_data)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .enc        (enc)
    );

endmodule

// ===== hdl/b64e_front.sv =====
// Front end: accepts bytes, tracks the group phase and builds character entries.
`include "assert_macros.svh"

module b64e_front
    import b64e_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    b64e_in_if.sink      msg,
    input  logic         q_full,
    output logic         push,
    output b64e_entry_t  entry
);

    b64e_phase_t phase_reg, phase_next;
    logic [3:0]  carry_reg, carry_next;
    logic [7:0]  b;

    assign msg.ready = !q_full;
    assign push      = msg.valid && !q_full;
    assign b         = msg.data_byte;

    always_comb
    begin
        phase_next = phase_reg;
        carry_next = carry_reg;
        if (push)
        begin
            case (phase_reg)
                PH_1:
                begin
                    phase_next = msg.msg_last ? PH_0 : PH_2;
                    carry_next = msg.msg_last ? 4'd0 : b[3:0];
                end
                PH_2:
                begin
                    phase_next = PH_0;
                    carry_next = 4'd0;
                end
                default:
                begin
                    phase_next = msg.msg_last ? PH_0 : PH_1;
                    carry_next = msg.msg_last ? 4'd0 : {2'b00, b[1:0]};
                end
            endcase
        end
    end

    always_comb
    begin
        entry.chars  = '{default: CHAR_PAD};
        entry.cnt_m1 = 2'd0;
        entry.last   = msg.msg_last;
        case (phase_reg)
            PH_1:
            begin
                entry.chars[0] = sym_char({carry_reg[1:0], b[7:4]});
                if (msg.msg_last)
                begin
                    entry.chars[1] = sym_char({b[3:0], 2'b00});
                    entry.cnt_m1   = 2'd2;
                end
            end
            PH_2:
            begin
                entry.chars[0] = sym_char({carry_reg, b[7:6]});
                entry.chars[1] = sym_char(b[5:0]);
                entry.cnt_m1   = 2'd1;
            end
            default:
            begin
                entry.chars[0] = sym_char(b[7:2]);
                if (msg.msg_last)
                begin
                    entry.chars[1] = sym_char({b[1:0], 4'b0000});
                    entry.cnt_m1   = 2'd3;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_0;
            carry_reg <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

    `B64E_ASSERT(a_carry_clear_at_start, (phase_reg == PH_0) |-> (carry_reg == 4'd0), "carry left over at group start")
    `B64E_ASSERT(a_carry_two_bits, (phase_reg == PH_1) |-> (carry_reg[3:2] == 2'b00), "carry wider than two bits after first byte")

endmodule

// ===== hdl/b64e_queue.sv =====
// Short entry queue between the front and back ends.
`include "assert_macros.svh"

module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = B64E_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  b64e_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output b64e_entry_t head,
    output logic        head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_entry_t        slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `B64E_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// ===== hdl/b64e_back.sv =====
// Back end: serialises queued entries into one character per transfer.
`include "assert_macros.svh"

module b64e_back
    import b64e_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  b64e_entry_t  head,
    input  logic         head_valid,
    output logic         pop,
    b64e_out_if.source   enc
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       out_last_reg;
    logic       load;
    logic       at_end;

    // Refill the output register when it is empty or being taken.
    assign load   = head_valid && (!out_valid_reg || enc.ready);
    assign at_end = (idx_reg == head.cnt_m1);
    assign pop    = load && at_end;

    assign enc.valid    = out_valid_reg;
    assign enc.out_char = out_char_reg;
    assign enc.out_last = out_last_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = at_end ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (enc.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= head.chars[idx_reg];
            out_last_reg <= at_end && head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `B64E_ASSERT(a_idx_within_entry, (idx_reg != 2'd0) |-> (head_valid && (idx_reg <= head.cnt_m1)), "character index outside the head entry")

endmodule

// ===== bench/base64_stream_encoder_core_tb.sv =====
// Self-checking base64 stream encoder bench: directed and random messages against a predictor.
module base64_stream_encoder_core_tb
    import b64e_pkg::*;
();

    typedef struct packed {
        logic [7:0] data_byte;
        logic       msg_last;
    } msg_byte_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } enc_char_t;

    logic clk;
    logic rst_n;

    b64e_in_if  msg_ch ();
    b64e_out_if enc_ch ();

    base64_stream_encoder_core u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_ch),
        .enc   (enc_ch)
    );

    string b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    msg_byte_t   byte_q[$];
    enc_char_t   char_expect_q[$];
    b64e_phase_t enc_phase;
    logic [3:0]  enc_carry;
    int          fail_count;
    int          src_idle_left;
    int          snk_stall_left;
    bit          src_calm;
    bit          snk_calm;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] symbol_of(logic [5:0] v);
        return b64_alphabet[v];
    endfunction

    function automatic void expect_char(logic [7:0] c, logic fin);
        enc_char_t e;
        e.out_char = c;
        e.out_last = fin;
        char_expect_q = {char_expect_q, e};
    endfunction

    // Work out the characters one byte transfer releases and advance the group state.
    function automatic void encode_byte(logic [7:0] b, logic fin);
        case (enc_phase)
            PH_1:
            begin
                expect_char(symbol_of({enc_carry[1:0], b[7:4]}), 1'b0);
                if (fin)
                begin
                    expect_char(symbol_of({b[3:0], 2'b00}), 1'b0);
                    expect_char(CHAR_PAD, 1'b1);
                    enc_phase = PH_0;
                    enc_carry = 4'd0;
                end
                else
                begin
                    enc_phase = PH_2;
                    enc_carry = b[3:0];
                end
            end
            PH_2:
            begin
                expect_char(symbol_of({enc_carry, b[7:6]}), 1'b0);
                expect_char(symbol_of(b[5:0]), fin);
                enc_phase = PH_0;
                enc_carry = 4'd0;
            end
            default:
            begin
                expect_char(symbol_of(b[7:2]), 1'b0);
                if (fin)
                begin
                    expect_char(symbol_of({b[1:0], 4'b0000}), 1'b0);
                    expect_char(CHAR_PAD, 1'b0);
                    expect_char(CHAR_PAD, 1'b1);
                    enc_phase = PH_0;
                    enc_carry = 4'd0;
                end
                else
                begin
                    enc_phase = PH_1;
                    enc_carry = {2'b00, b[1:0]};
                end
            end
        endcase
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 20);
    endfunction

    task automatic add_msg(input logic [7:0] bytes[], input int len);
        msg_byte_t m;
        for (int i = 0; i < len; i++)
        begin
            m.data_byte = bytes[i];
            m.msg_last  = (i == len - 1);
            byte_q = {byte_q, m};
        end
    endtask

    initial
    begin
        logic [7:0] buf_bytes[];
        int         n_items;
        int         len;

        // Lone bytes, then two- and three-byte messages, mostly at the extremes, then a longer one.
        buf_bytes = '{8'h00};                          add_msg(buf_bytes, 1);
        buf_bytes = '{8'hFF};                          add_msg(buf_bytes, 1);
        buf_bytes = '{8'hF8, 8'h00};                   add_msg(buf_bytes, 2);
        buf_bytes = '{8'hFF, 8'hFF};                   add_msg(buf_bytes, 2);
        buf_bytes = '{8'h00, 8'h00, 8'h00};            add_msg(buf_bytes, 3);
        buf_bytes = '{8'hFF, 8'hFF, 8'hFF};            add_msg(buf_bytes, 3);
        buf_bytes = '{8'h4D, 8'h61, 8'h6E};            add_msg(buf_bytes, 3);
        buf_bytes = '{8'hFB, 8'hEF, 8'hBE, 8'h01, 8'h80, 8'h7F, 8'h3E};
        add_msg(buf_bytes, 7);

        n_items = 0;
        while (n_items < 232)
        begin
            len = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 6) : $urandom_range(7, 16);
            buf_bytes = new[len];
            foreach (buf_bytes[i])
                buf_bytes[i] = 8'($urandom_range(0, 255));
            add_msg(buf_bytes, len);
            n_items += len;
        end
    end

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        msg_ch.valid        = 1'b0;
        msg_ch.data_byte    = 8'h00;
        msg_ch.msg_last     = 1'b0;
        enc_ch.ready        = 1'b0;
        enc_phase           = PH_0;
        enc_carry           = 4'd0;
        fail_count          = 0;
        src_idle_left       = 0;
        snk_stall_left      = 0;
        src_calm            = 1'b0;
        snk_calm            = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: hold each byte until its transfer, then idle or load the next one.
    always @(posedge clk)
    begin
        bit        busy;
        msg_byte_t nxt;
        if (rst_n)
        begin
            busy = msg_ch.valid;
            if (msg_ch.valid && msg_ch.ready)
            begin
                encode_byte(msg_ch.data_byte, msg_ch.msg_last);
                busy = 1'b0;
                if ($urandom_range(0, 29) == 0)
                    src_calm = !src_calm;
                src_idle_left = src_calm ? 0 : gap_length();
            end
            if (!busy)
            begin
                if (src_idle_left > 0)
                    src_idle_left--;
                else if (byte_q.size() > 0)
                begin
                    nxt = byte_q.pop_front();
                    msg_ch.valid     <= 1'b1;
                    msg_ch.data_byte <= nxt.data_byte;
                    msg_ch.msg_last  <= nxt.msg_last;
                    busy = 1'b1;
                end
            end
            if (!busy)
                msg_ch.valid <= 1'b0;
        end
    end

    // Monitor: check every character transfer, then pick ready for the next cycle.
    always @(posedge clk)
    begin
        enc_char_t want;
        if (rst_n)
        begin
            if (enc_ch.valid && enc_ch.ready)
            begin
                if (char_expect_q.size() == 0)
                begin
                    $error("unexpected character: out_char %h, out_last %b",
                           enc_ch.out_char, enc_ch.out_last);
                    fail_count++;
                end
                else
                begin
                    want = char_expect_q.pop_front();
                    if (enc_ch.out_char !== want.out_char)
                    begin
                        $error("out_char mismatch: expected %h, got %h",
                               want.out_char, enc_ch.out_char);
                        fail_count++;
                    end
                    if (enc_ch.out_last !== want.out_last)
                    begin
                        $error("out_last mismatch: expected %b, got %b",
                               want.out_last, enc_ch.out_last);
                        fail_count++;
                    end
                end
            end
            if ($urandom_range(0, 99) == 0)
                snk_calm = !snk_calm;
            if (snk_stall_left > 0)
            begin
                snk_stall_left--;
                enc_ch.ready <= 1'b0;
            end
            else if (!snk_calm && $urandom_range(0, 99) < 25)
            begin
                snk_stall_left = gap_length();
                enc_ch.ready <= 1'b0;
            end
            else
                enc_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (byte_q.size() > 0 || msg_ch.valid === 1'b1 || char_expect_q.size() > 0)
            @(posedge clk);
        // Allow any stray characters to surface.
        repeat (40) @(posedge clk);
        if (char_expect_q.size() > 0)
        begin
            $error("characters still expected at end: %0d", char_expect_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("** base64_stream_encoder_core: PASSED **");
        else
            $display("** base64_stream_encoder_core: FAILED **");
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout");
        $display("** base64_stream_encoder_core: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/b64e_pkg.sv
hdl/b64e_in_if.sv
hdl/b64e_out_if.sv
hdl/b64e_front.sv
hdl/b64e_queue.sv
hdl/b64e_back.sv
hdl/base64_stream_encoder_core.sv
bench/base64_stream_encoder_core_tb.sv
